// ===== rtl/crlf_lrx_pkg.sv =====
package crlf_lrx_pkg;

  localparam int MAX_LINE_W     = 9;
  localparam int MAX_LINE_RST   = 256;
  localparam int LINE_DEPTH_DEF = 256;
  localparam int NUM_SLOTS      = 3;
  localparam int SLOT_W         = 2;
  localparam int LEN_W          = 8;
  localparam int BYTE_W         = 8;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;

  typedef enum logic [1:0] {
    KIND_RX     = 2'd0,
    KIND_LOCK   = 2'd1,
    KIND_UNLOCK = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    EV_STORED   = 4'd0,
    EV_CR       = 4'd1,
    EV_DONE     = 4'd2,
    EV_BADTERM  = 4'd3,
    EV_OVERFLOW = 4'd4,
    EV_LOCKED   = 4'd5,
    EV_NOREADY  = 4'd6,
    EV_UNLOCKED = 4'd7,
    EV_READ     = 4'd8,
    EV_NOOP     = 4'd9
  } ev_t;

  typedef struct packed {
    ev_t               ev;
    logic              done;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data;
  } res_t;

  // lowest slot that is neither ready nor held
  function automatic logic [SLOT_W-1:0] next_free(input logic [SLOT_W-1:0] rdy_slot,
                                                  input logic              rdy_valid,
                                                  input logic [SLOT_W-1:0] hld_slot,
                                                  input logic              hld_valid);
    logic [SLOT_W-1:0] pick;
    pick = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!(rdy_valid && rdy_slot == SLOT_W'(i)) && !(hld_valid && hld_slot == SLOT_W'(i))) begin
        pick = SLOT_W'(i);
      end
    end
    return pick;
  endfunction

endpackage

// ===== rtl/crlf_line_receiver_triple_buffer_core.sv =====
// crlf line receiver with three line buffers
//
// input channel (in_valid / in_stall): one word per command; kind selects a
// received serial byte, lock of the ready line, unlock of the held line, or a
// read of one byte of the held line at read_offset
// output channel (out_valid / out_stall): exactly one result word per command
// config: cfg_wr_en / cfg_wr_data write max_line at any edge
//
// the three line buffers share one single-port-write, registered-read memory
// of 3*LINE_DEPTH bytes. byte, lock and unlock commands finish in the accept
// cycle; a read passes the read state for the registered memory read. a new
// command is taken only after the last result leaves the internal register.
// an unlock with a held line also zero-fills min(max_line, LINE_DEPTH) bytes,
// one memory write per cycle, during which no command is accepted
// after reset the whole memory is cleared, with in_stall high throughout;
// config writes are taken during that time
// a result sits in an internal register and then in the output register, so
// when the receiver stalls one more command can still finish before in_stall
// rises; nothing is dropped
module crlf_line_receiver_triple_buffer_core #(
  parameter int LINE_DEPTH = crlf_lrx_pkg::LINE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config port
  input  logic                                cfg_wr_en,
  input  logic [crlf_lrx_pkg::MAX_LINE_W-1:0] cfg_wr_data,
  // command channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [crlf_lrx_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [crlf_lrx_pkg::BYTE_W-1:0]     read_offset,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [3:0]                          event_res,
  output logic                                line_done,
  output logic [crlf_lrx_pkg::SLOT_W-1:0]     slot,
  output logic [crlf_lrx_pkg::LEN_W-1:0]      length,
  output logic [crlf_lrx_pkg::BYTE_W-1:0]     read_data
);

  localparam int CW        = crlf_lrx_pkg::MAX_LINE_W;
  localparam int SW        = crlf_lrx_pkg::SLOT_W;
  localparam int LW        = crlf_lrx_pkg::LEN_W;
  localparam int BW        = crlf_lrx_pkg::BYTE_W;
  localparam int MEM_DEPTH = crlf_lrx_pkg::NUM_SLOTS * LINE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  // width wide enough to compare max_line or an offset against LINE_DEPTH
  localparam int DW        = $clog2(LINE_DEPTH + 1);
  localparam int WW        = (CW > DW) ? CW : DW;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WIPE  = 4'b1000
  } state_t;

  function automatic logic [AW-1:0] slot_base(input logic [SW-1:0] s);
    case (s)
      2'd1:    return AW'(LINE_DEPTH);
      2'd2:    return AW'(2 * LINE_DEPTH);
      default: return '0;
    endcase
  endfunction

  // line memory
  logic [BW-1:0] mem [MEM_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [BW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [BW-1:0] mem_rdata;

  // control state
  state_t        state, state_next;
  logic [AW-1:0] sweep_cnt, sweep_cnt_next;
  logic [AW-1:0] sweep_last, sweep_last_next;
  logic [AW-1:0] sweep_base, sweep_base_next;
  logic [CW-1:0] max_line;
  logic [CW-1:0] byte_count, byte_count_next;
  logic          cr_seen, cr_seen_next;
  logic [SW-1:0] write_slot, write_slot_next;
  logic [SW-1:0] ready_slot, ready_slot_next;
  logic          ready_valid, ready_valid_next;
  logic [LW-1:0] ready_length, ready_length_next;
  logic [SW-1:0] held_slot, held_slot_next;
  logic          held_valid, held_valid_next;
  logic [LW-1:0] held_length, held_length_next;
  logic          rd_oob, rd_oob_next;

  // result staging
  crlf_lrx_pkg::res_t res, res_in;
  logic               res_valid;
  logic               res_set;
  logic               res_move;

  logic          acc;
  logic          rd_in_range;
  logic [CW-1:0] lim_clamp;
  logic [CW-1:0] lim_eff;
  logic [CW:0]   cnt_inc;
  logic          ovf;
  logic [AW-1:0] wr_base;
  logic [AW-1:0] hd_base;

  assign in_stall = (state != ST_IDLE) || res_valid;
  assign acc      = in_valid && !in_stall;
  assign res_move = res_valid && (!out_valid || !out_stall);

  // effective line limit: max_line clamped to the buffer size, zero acts as one
  assign lim_clamp   = (WW'(max_line) > WW'(LINE_DEPTH)) ? CW'(LINE_DEPTH) : max_line;
  assign lim_eff     = (lim_clamp == '0) ? CW'(1) : lim_clamp;
  assign cnt_inc     = {1'b0, byte_count} + (CW + 1)'(1);
  assign ovf         = cnt_inc >= {1'b0, lim_eff};
  assign wr_base     = slot_base(write_slot);
  assign hd_base     = slot_base(held_slot);
  assign rd_in_range = WW'(read_offset) < WW'(LINE_DEPTH);

  always_comb begin
    state_next        = state;
    sweep_cnt_next    = sweep_cnt;
    sweep_last_next   = sweep_last;
    sweep_base_next   = sweep_base;
    byte_count_next   = byte_count;
    cr_seen_next      = cr_seen;
    write_slot_next   = write_slot;
    ready_slot_next   = ready_slot;
    ready_valid_next  = ready_valid;
    ready_length_next = ready_length;
    held_slot_next    = held_slot;
    held_valid_next   = held_valid;
    held_length_next  = held_length;
    rd_oob_next       = rd_oob;
    mem_we            = 1'b0;
    mem_waddr         = wr_base + AW'(byte_count);
    mem_wdata         = rx_byte;
    mem_raddr         = hd_base + (rd_in_range ? AW'(read_offset) : '0);
    res_set           = 1'b0;
    res_in            = '0;
    res_in.ev         = crlf_lrx_pkg::EV_NOOP;

    case (state)
      ST_CLEAR, ST_WIPE: begin
        // zero-fill sweep: all memory after reset, lim_clamp bytes on unlock
        mem_we         = 1'b1;
        mem_waddr      = sweep_base + sweep_cnt;
        mem_wdata      = '0;
        sweep_cnt_next = sweep_cnt + AW'(1);
        if (sweep_cnt == sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          res_set = 1'b1;
          case (kind)
            crlf_lrx_pkg::KIND_RX: begin
              res_in.slot = write_slot;
              if (cr_seen) begin
                cr_seen_next = 1'b0;
                if (rx_byte != crlf_lrx_pkg::CH_LF) begin
                  // cr without lf drops the line
                  byte_count_next = '0;
                  res_in.ev       = crlf_lrx_pkg::EV_BADTERM;
                end else begin
                  ready_slot_next   = write_slot;
                  ready_valid_next  = 1'b1;
                  ready_length_next = byte_count[LW-1:0];
                  byte_count_next   = '0;
                  write_slot_next   = crlf_lrx_pkg::next_free(write_slot, 1'b1,
                                                              held_slot, held_valid);
                  res_in.ev         = crlf_lrx_pkg::EV_DONE;
                  res_in.done       = 1'b1;
                  res_in.length     = byte_count[LW-1:0];
                end
              end else if (rx_byte == crlf_lrx_pkg::CH_CR) begin
                cr_seen_next  = 1'b1;
                res_in.ev     = crlf_lrx_pkg::EV_CR;
                res_in.length = byte_count[LW-1:0];
              end else begin
                mem_we = 1'b1;
                if (ovf) begin
                  byte_count_next = '0;
                  res_in.ev       = crlf_lrx_pkg::EV_OVERFLOW;
                  res_in.length   = '0;
                end else begin
                  byte_count_next = cnt_inc[CW-1:0];
                  res_in.ev       = crlf_lrx_pkg::EV_STORED;
                  res_in.length   = cnt_inc[LW-1:0];
                end
              end
            end
            crlf_lrx_pkg::KIND_LOCK: begin
              if (ready_valid) begin
                held_slot_next   = ready_slot;
                held_length_next = ready_length;
                held_valid_next  = 1'b1;
                ready_valid_next = 1'b0;
                res_in.ev        = crlf_lrx_pkg::EV_LOCKED;
                res_in.slot      = ready_slot;
                res_in.length    = ready_length;
              end else begin
                res_in.ev = crlf_lrx_pkg::EV_NOREADY;
              end
            end
            crlf_lrx_pkg::KIND_UNLOCK: begin
              if (held_valid) begin
                held_valid_next = 1'b0;
                res_in.ev       = crlf_lrx_pkg::EV_UNLOCKED;
                res_in.slot     = held_slot;
                res_in.length   = held_length;
                if (lim_clamp != '0) begin
                  state_next      = ST_WIPE;
                  sweep_base_next = hd_base;
                  sweep_cnt_next  = '0;
                  sweep_last_next = AW'(lim_clamp - CW'(1));
                end
              end
            end
            crlf_lrx_pkg::KIND_READ: begin
              if (held_valid) begin
                // result comes after the memory read
                res_set     = 1'b0;
                rd_oob_next = !rd_in_range;
                state_next  = ST_READ;
              end
            end
            default: begin
              res_in.ev = crlf_lrx_pkg::EV_NOOP;
            end
          endcase
        end
      end
      ST_READ: begin
        res_set       = 1'b1;
        res_in.ev     = crlf_lrx_pkg::EV_READ;
        res_in.slot   = held_slot;
        res_in.length = held_length;
        res_in.data   = rd_oob ? '0 : mem_rdata;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      sweep_cnt    <= '0;
      sweep_last   <= AW'(MEM_DEPTH - 1);
      sweep_base   <= '0;
      max_line     <= CW'(crlf_lrx_pkg::MAX_LINE_RST);
      byte_count   <= '0;
      cr_seen      <= 1'b0;
      write_slot   <= '0;
      ready_slot   <= '0;
      ready_valid  <= 1'b0;
      ready_length <= '0;
      held_slot    <= '0;
      held_valid   <= 1'b0;
      held_length  <= '0;
      rd_oob       <= 1'b0;
      res_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      sweep_cnt    <= sweep_cnt_next;
      sweep_last   <= sweep_last_next;
      sweep_base   <= sweep_base_next;
      byte_count   <= byte_count_next;
      cr_seen      <= cr_seen_next;
      write_slot   <= write_slot_next;
      ready_slot   <= ready_slot_next;
      ready_valid  <= ready_valid_next;
      ready_length <= ready_length_next;
      held_slot    <= held_slot_next;
      held_valid   <= held_valid_next;
      held_length  <= held_length_next;
      rd_oob       <= rd_oob_next;
      if (cfg_wr_en) begin
        max_line <= cfg_wr_data;
      end
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (res_set) begin
      res <= res_in;
    end
    if (res_move) begin
      event_res <= res.ev;
      line_done <= res.done;
      slot      <= res.slot;
      length    <= res.length;
      read_data <= res.data;
    end
  end

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");

  a_ready_held_apart : assert property (@(posedge clk) disable iff (rst)
    (ready_valid && held_valid) |-> (ready_slot != held_slot))
    else $error("ready and held lines share a buffer");

  a_write_slot_free : assert property (@(posedge clk) disable iff (rst)
    (!(ready_valid && ready_slot == write_slot)) && (!(held_valid && held_slot == write_slot))
    && (write_slot != 2'd3))
    else $error("write buffer overlaps ready or held line");

  a_no_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR || state == ST_WIPE || state == ST_READ) |-> !acc)
    else $error("command accepted while memory sweep or read in flight");

  a_done_event : assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_done) |-> (event_res == crlf_lrx_pkg::EV_DONE))
    else $error("line_done without line complete event");
`endif

endmodule
